/* rtl/assert_macros.svh */
// Assertion macros used by the rotozoom texel fetch core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true at a clock edge out of reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif

`endif

/* rtl/rtz_pkg.sv */
// Types and constants shared by the rotozoom texel fetch modules.
package rtz_pkg;

    localparam int COEF_W    = 18;
    localparam int FRAC_BITS = 14;
    localparam int TEX_SIZE  = 256;
    localparam int COORD_W   = $clog2(TEX_SIZE);
    localparam int PIX_W     = 11;
    localparam int ADDR_W    = 2 * COORD_W;
    localparam int TEXEL_W   = 8;
    localparam int PROD_W    = PIX_W + 1 + COEF_W;
    localparam int SUM_W     = PROD_W + 1;

    localparam logic signed [COEF_W-1:0] COS_RESET = 18'sd18022;
    localparam logic signed [COEF_W-1:0] SIN_RESET = 18'sd0;

    typedef enum logic
    {
        FUNC_WRITE  = 1'b0,
        FUNC_RENDER = 1'b1
    } func_t;

    typedef enum logic
    {
        REG_COS_ZOOM = 1'b0,
        REG_SIN_ZOOM = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        logic signed [COEF_W-1:0] cos_zoom;
        logic signed [COEF_W-1:0] sin_zoom;
    } coef_t;

    typedef struct packed
    {
        func_t              func;
        logic [PIX_W-1:0]   pix_x;
        logic [PIX_W-1:0]   pix_y;
        logic [ADDR_W-1:0]  texel_addr;
        logic [TEXEL_W-1:0] texel_value;
    } s1_item_t;

    typedef struct packed
    {
        func_t                    func;
        logic signed [PROD_W-1:0] x_cos;
        logic signed [PROD_W-1:0] x_sin;
        logic signed [PROD_W-1:0] y_cos;
        logic signed [PROD_W-1:0] y_sin;
        logic [ADDR_W-1:0]        texel_addr;
        logic [TEXEL_W-1:0]       texel_value;
    } s2_item_t;

    // Truncate toward zero by the fraction bits, then wrap into the texture.
    // Arithmetic shift floors; a negative value with a nonzero fraction
    // needs one added back to round toward zero.
    function automatic logic [COORD_W-1:0] trunc_wrap(input logic signed [SUM_W-1:0] num);
        logic [SUM_W-FRAC_BITS-1:0] quot;
        logic                       round_up;
        quot     = num[SUM_W-1:FRAC_BITS];
        round_up = num[SUM_W-1] && (num[FRAC_BITS-1:0] != '0);
        return quot[COORD_W-1:0] + COORD_W'(round_up);
    endfunction

endpackage

/* rtl/rotozoom_texel_fetch_core.sv */
// A render item's result becomes valid when the item reaches the texture memory read register.
// Throughput: one item per cycle while m_tready does not stall the output; input register, product register and the
// texture memory read register form the three pipeline stages.
// Texel write items update the memory in the third stage and give no result.
// Reset (rst_n, asynchronous, active low) clears the stage valids and loads the
// coefficient reset values; the texture memory is not cleared.
`include "assert_macros.svh"

module rotozoom_texel_fetch_core
    import rtz_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Configuration write port.
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [COEF_W-1:0] cfg_wdata,
    // Input items.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,   // pix_x, pix_y, texel_addr, texel_value, zero fill
    input  logic              s_tuser,   // func
    // Result items.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata    // pixel, tex_u, tex_v
);

    coef_t              coef;
    logic               s1_valid_reg;
    s1_item_t           s1_item_reg;
    s1_item_t           s1_item_next;
    logic               s2_ready;
    logic               s2_valid;
    s2_item_t           s2_item;
    logic               out_ready;
    logic               load3;
    logic               m_valid_reg;
    logic signed [SUM_W-1:0] u_num;
    logic signed [SUM_W-1:0] v_num;
    logic [COORD_W-1:0] u_wrap;
    logic [COORD_W-1:0] v_wrap;
    logic [COORD_W-1:0] tex_u_reg;
    logic [COORD_W-1:0] tex_v_reg;
    logic               mem_wr_en;
    logic               mem_rd_en;
    logic [TEXEL_W-1:0] mem_rd_data;

    rtz_coef_regs u_coef_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .coef      (coef)
    );

    // Unpack the input item.
    always_comb
    begin
        s1_item_next.func        = func_t'(s_tuser);
        s1_item_next.pix_x       = s_tdata[10:0];
        s1_item_next.pix_y       = s_tdata[21:11];
        s1_item_next.texel_addr  = s_tdata[37:22];
        s1_item_next.texel_value = s_tdata[45:38];
    end

    // Input register stage.
    assign s_tready = !s1_valid_reg || s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_item_reg <= s1_item_next;
        end
    end

    rtz_mult_stage u_mult_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef),
        .in_valid  (s1_valid_reg),
        .in_item   (s1_item_reg),
        .in_ready  (s2_ready),
        .out_valid (s2_valid),
        .out_item  (s2_item),
        .out_ready (out_ready)
    );

    // Rotate sums, truncation and wrap into texture coordinates.
    always_comb
    begin
        u_num  = SUM_W'(s2_item.x_cos) - SUM_W'(s2_item.y_sin);
        v_num  = SUM_W'(s2_item.x_sin) + SUM_W'(s2_item.y_cos);
        u_wrap = trunc_wrap(u_num);
        v_wrap = trunc_wrap(v_num);
    end

    // Memory stage: writes store the texel, renders read it into the result.
    assign out_ready = !m_valid_reg || m_tready;
    assign load3     = s2_valid && out_ready;
    assign mem_wr_en = load3 && (s2_item.func == FUNC_WRITE);
    assign mem_rd_en = load3 && (s2_item.func == FUNC_RENDER);

    rtz_tex_mem u_tex_mem
    (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (s2_item.texel_addr),
        .wr_data (s2_item.texel_value),
        .rd_en   (mem_rd_en),
        .rd_addr ({u_wrap, v_wrap}),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            m_valid_reg <= s2_valid && (s2_item.func == FUNC_RENDER);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_rd_en)
        begin
            tex_u_reg <= u_wrap;
            tex_v_reg <= v_wrap;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {tex_v_reg, tex_u_reg, mem_rd_data};

    // A texel write leaving the product stage never shows up as a result.
    `ASSERT_CLK(a_write_no_result, mem_wr_en |=> !m_tvalid, "texel write produced a result")
    // The input side stalls only when every stage holds an item.
    `ASSERT_CLK(a_stall_full, !s_tready |-> (s1_valid_reg && s2_valid && m_valid_reg && !m_tready), "input stalled with room in the pipeline")
    // A taken result with nothing behind it leaves the output empty.
    `ASSERT_CLK(a_drain, (m_tvalid && m_tready && !s2_valid) |=> !m_tvalid, "result repeated after it was taken")
    // One memory access per item.
    `ASSERT_NEVER(a_one_access, mem_wr_en && mem_rd_en, "texture memory read and written by one item")

endmodule

/* rtl/rtz_coef_regs.sv */
// Per-frame rotation and zoom coefficient registers.
module rtz_coef_regs
    import rtz_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [COEF_W-1:0] cfg_wdata,
    output coef_t             coef
);

    coef_t coef_reg;
    coef_t coef_next;

    // Decode the register index of a write.
    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_COS_ZOOM: coef_next.cos_zoom = $signed(cfg_wdata);
                REG_SIN_ZOOM: coef_next.sin_zoom = $signed(cfg_wdata);
                default:      coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.cos_zoom <= COS_RESET;
            coef_reg.sin_zoom <= SIN_RESET;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

/* rtl/rtz_mult_stage.sv */
// Pipeline stage that forms the four coordinate products of a pixel.
module rtz_mult_stage
    import rtz_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  coef_t    coef,
    input  logic     in_valid,
    input  s1_item_t in_item,
    output logic     in_ready,
    output logic     out_valid,
    output s2_item_t out_item,
    input  logic     out_ready
);

    logic                     valid_reg;
    s2_item_t                 item_reg;
    s2_item_t                 item_next;
    logic signed [PIX_W:0]    x_s;
    logic signed [PIX_W:0]    y_s;

    // Screen coordinates are unsigned; a zero sign bit makes them signed.
    always_comb
    begin
        x_s                   = $signed({1'b0, in_item.pix_x});
        y_s                   = $signed({1'b0, in_item.pix_y});
        item_next.func        = in_item.func;
        item_next.x_cos       = x_s * coef.cos_zoom;
        item_next.x_sin       = x_s * coef.sin_zoom;
        item_next.y_cos       = y_s * coef.cos_zoom;
        item_next.y_sin       = y_s * coef.sin_zoom;
        item_next.texel_addr  = in_item.texel_addr;
        item_next.texel_value = in_item.texel_value;
    end

    assign in_ready = !valid_reg || out_ready;

    // Stage valid moves whenever the stage can pass its item on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Product payload loads only with a new item.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* rtl/rtz_tex_mem.sv */
// Texture memory with one write and one registered read per cycle.
module rtz_tex_mem
    import rtz_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [TEXEL_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [TEXEL_W-1:0] rd_data
);

    logic [TEXEL_W-1:0] mem [2**ADDR_W];
    logic [TEXEL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sim/rotozoom_texel_fetch_core_tb.sv */
// Self-checking testbench for the rotozoom texel fetch core: directed corners and random streams.
module rotozoom_texel_fetch_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtz_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 40;
    localparam int STORE_DEPTH  = 1 << ADDR_W;

    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};

    // One result item as it appears on m_tdata, lowest field last.
    typedef struct packed
    {
        logic [COORD_W-1:0] tex_v;
        logic [COORD_W-1:0] tex_u;
        logic [TEXEL_W-1:0] pixel;
    } pixel_result_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic              cfg_index = REG_COS_ZOOM;
    logic [COEF_W-1:0] cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata   = '0;  // pix_x, pix_y, texel_addr, texel_value, zero fill
    logic              s_tuser   = FUNC_WRITE;  // func
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [23:0]       m_tdata;     // pixel, tex_u, tex_v

    // Shadow copy of the texture and coefficients.
    logic [TEXEL_W-1:0]       texel_shadow [STORE_DEPTH];
    bit                       texel_written [STORE_DEPTH];
    logic signed [COEF_W-1:0] cos_coef = COS_RESET;
    logic signed [COEF_W-1:0] sin_coef = SIN_RESET;
    pixel_result_t            pending_pixels [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    rotozoom_texel_fetch_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    // Truncate toward zero by the fraction bits, then wrap into the texture.
    function automatic logic [COORD_W-1:0] wrap_coord(input longint num);
        longint quot;
        longint rem;
        quot = num / (longint'(1) << FRAC_BITS);
        rem  = quot % TEX_SIZE;
        if (rem < 0)
        begin
            rem += TEX_SIZE;
        end
        return rem[COORD_W-1:0];
    endfunction

    // Texture address {u, v} that a screen pixel maps to under the current coefficients.
    function automatic logic [ADDR_W-1:0] texel_address(input logic [PIX_W-1:0] x,
                                                        input logic [PIX_W-1:0] y);
        longint xs;
        longint ys;
        longint cz;
        longint sz;
        xs = longint'(x);
        ys = longint'(y);
        cz = longint'(cos_coef);
        sz = longint'(sin_coef);
        return {wrap_coord(xs * cz - ys * sz), wrap_coord(xs * sz + ys * cz)};
    endfunction

    // Apply one accepted item to the shadow state and queue the pixel it should fetch.
    function automatic void texel_fetch_predict(input func_t func,
                                                input logic [PIX_W-1:0] x,
                                                input logic [PIX_W-1:0] y,
                                                input logic [ADDR_W-1:0] addr,
                                                input logic [TEXEL_W-1:0] value);
        logic [ADDR_W-1:0] raddr;
        pixel_result_t     res;
        if (func == FUNC_WRITE)
        begin
            texel_shadow[addr]  = value;
            texel_written[addr] = 1'b1;
        end
        else
        begin
            raddr     = texel_address(x, y);
            res.pixel = texel_shadow[raddr];
            res.tex_u = raddr[ADDR_W-1:COORD_W];
            res.tex_v = raddr[COORD_W-1:0];
            pending_pixels.insert(pending_pixels.size(), res);
        end
    endfunction

    function automatic logic signed [COEF_W-1:0] pick_coef();
        case ($urandom_range(9))
            0: return COEF_MIN;
            1: return COEF_MAX;
            2: return '0;
            3, 4, 5: return COEF_W'(int'($urandom_range(65535)) - 32768);
            default: return COEF_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS)
        begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // Send one item, called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input func_t func,
                             input logic [PIX_W-1:0] x,
                             input logic [PIX_W-1:0] y,
                             input logic [ADDR_W-1:0] addr,
                             input logic [TEXEL_W-1:0] value);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {2'b00, value, addr, y, x};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        texel_fetch_predict(func, x, y, addr, value);
        @(negedge clk);
    endtask

    // Render a pixel, first writing its texel if that entry has never been written.
    task automatic render_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
        logic [ADDR_W-1:0] target;
        target = texel_address(x, y);
        if (!texel_written[target])
        begin
            send_item(FUNC_WRITE, PIX_W'($urandom), PIX_W'($urandom), target,
                      TEXEL_W'($urandom));
        end
        send_item(FUNC_RENDER, x, y, ADDR_W'($urandom), TEXEL_W'($urandom));
    endtask

    // Stop sending and wait until every result is in and the pipeline is empty.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_coefs(input logic signed [COEF_W-1:0] cz,
                             input logic signed [COEF_W-1:0] sz);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_COS_ZOOM;
        cfg_wdata <= cz;
        @(negedge clk);
        cfg_index <= REG_SIN_ZOOM;
        cfg_wdata <= sz;
        @(negedge clk);
        cfg_we   <= 1'b0;
        cos_coef = cz;
        sin_coef = sz;
    endtask

    // Reset coefficients, store extremes and a write followed at once by a read of it.
    task automatic test_reset_coefs();
        send_item(FUNC_WRITE, '0, '0, '0, 8'hFF);
        send_item(FUNC_RENDER, '0, '0, '1, '1);
        send_item(FUNC_WRITE, '1, '1, '0, 8'h00);
        send_item(FUNC_RENDER, '0, '0, '0, '0);
        send_item(FUNC_WRITE, '0, '0, '1, 8'hA5);
        render_pixel('1, '1);
        render_pixel('1, '0);
        render_pixel('0, '1);
        render_pixel(11'd1, 11'd1);
    endtask

    // Coefficient extremes, and negative coordinates truncated toward zero.
    task automatic test_coef_extremes();
        set_coefs(COEF_MIN, COEF_MAX);
        render_pixel('1, '1);
        render_pixel('1, '0);
        render_pixel('0, '1);
        set_coefs(COEF_MAX, COEF_MIN);
        render_pixel('1, '1);
        render_pixel('1, '0);
        render_pixel('0, '1);
        // Just below -1.0: a fraction that must round up toward zero.
        set_coefs(-18'sd16385, '0);
        render_pixel(11'd1, 11'd0);
        render_pixel(11'd0, 11'd1);
        // Exact negative integers need no rounding.
        set_coefs(-18'sd16384, -18'sd16384);
        render_pixel(11'd3, 11'd0);
        set_coefs('0, '0);
        render_pixel('1, '1);
    endtask

    // Random mix of texel writes and renders under changing coefficients.
    task automatic test_random_stream(input int n_items, input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 64 == 0)
            begin
                set_coefs(pick_coef(), pick_coef());
            end
            if ($urandom_range(99) < 30)
            begin
                send_item(FUNC_WRITE, PIX_W'($urandom), PIX_W'($urandom), ADDR_W'($urandom),
                          TEXEL_W'($urandom));
            end
            else if ($urandom_range(1) == 0)
            begin
                render_pixel(PIX_W'($urandom_range(63)), PIX_W'($urandom_range(63)));
            end
            else
            begin
                render_pixel(PIX_W'($urandom), PIX_W'($urandom));
            end
        end
    endtask

    // Result receiver back-pressure.
    always @(negedge clk)
    begin
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result item with the oldest expected pixel.
    always @(posedge clk)
    begin : result_check
        pixel_result_t got;
        pixel_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_pixels.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", got));
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got.pixel !== want.pixel)
                begin
                    report_mismatch($sformatf("pixel %h, expected %h", got.pixel, want.pixel));
                end
                if (got.tex_u !== want.tex_u)
                begin
                    report_mismatch($sformatf("tex_u %h, expected %h", got.tex_u, want.tex_u));
                end
                if (got.tex_v !== want.tex_v)
                begin
                    report_mismatch($sformatf("tex_v %h, expected %h", got.tex_v, want.tex_v));
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_reset_coefs();
        test_coef_extremes();
        // Most renders need a texel write first, so each loop step sends
        // a little over one and a half items on average.
        test_random_stream(160, 0, 0);
        test_random_stream(160, 72, 0);
        test_random_stream(160, 0, 72);
        test_random_stream(150, 23, 23);

        wait_idle();
        if (mismatch_count == 0 && pending_pixels.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
